// File: src/gelu_pkg.sv
// ---------------------------------------------------------------------------
// gelu_pkg
// Shared constants and the elaboration-time tanh table builder for the
// tanh-approximated GELU activation.
// ---------------------------------------------------------------------------
package gelu_pkg;

    localparam int COEF_W    = 26;
    localparam int SQRT2PI_W = 30;
    localparam int Q_SHIFT   = 30;

    // 0.044715 and sqrt(2/pi) in Q30
    localparam logic [COEF_W-1:0]    COEF_Q30    = 26'd48012366;
    localparam logic [SQRT2PI_W-1:0] SQRT2PI_Q30 = 30'd856722024;

    localparam logic [63:0] Q31_ONE = 64'd1 << 31;

    // tanh in Q(.frac) from z = 2a/256 in Q31
    function automatic logic [63:0] tanh_entry(logic [63:0] z, int unsigned frac);
        logic [63:0] z2;
        logic [63:0] z3;
        logic [63:0] z4;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] t;
        z2 = (z * z) >> 31;
        z3 = (z2 * z) >> 31;
        z4 = (z3 * z) >> 31;
        e  = Q31_ONE - z + z2 / 2 - z3 / 6 + z4 / 24;
        for (int s = 0; s < 8; s++)
        begin
            e = (e * e + (Q31_ONE >> 1)) >> 31;
        end
        num = (Q31_ONE - e) << 31;
        den = Q31_ONE + e;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        t = (quo + (64'd1 << (30 - frac))) >> (31 - frac);
        if (t > (64'd1 << frac))
        begin
            t = 64'd1 << frac;
        end
        return t;
    endfunction

endpackage

// File: src/gelu_tanh_activation.sv
// ---------------------------------------------------------------------------
// gelu_tanh_activation
// Streaming GELU, tanh form, on signed fixed-point words with a last flag.
// ---------------------------------------------------------------------------
// Takes one word per clock cycle: busy is held low, so every cycle with start
// high accepts a word. The datapath is nine register stages (the magnitude,
// three multiplies for the cubic term, one scale, the table index, the tanh
// table read, the final multiply and the saturating output register), so each
// result shows on sample_out and last_out with done high for one cycle, in
// input order, once its word has passed every stage. The receiver cannot stall
// the stream. Inputs of magnitude 4.0 or more skip the table and use tanh = 1.
module gelu_tanh_activation #(
    parameter int DATA_WIDTH       = 16,
    parameter int FRAC_BITS        = 12,
    parameter int TANH_TABLE_DEPTH = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [DATA_WIDTH-1:0] sample_in,
    input  logic                  last_in,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] sample_out,
    output logic                  last_out
);
    import gelu_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int PW  = F + 2;
    localparam int TW  = F + 1;
    localparam int AW  = (TANH_TABLE_DEPTH > 1) ? $clog2(TANH_TABLE_DEPTH) : 1;
    localparam int IW  = AW + 1;
    localparam int CW  = (DW > F + 3) ? DW : F + 3;
    localparam int NST = 8;

    localparam logic [CW-1:0]   FOUR_LIM = CW'(4) << F;
    localparam logic [IW-1:0]   DEPTH_I  = IW'(TANH_TABLE_DEPTH);
    localparam logic [TW-1:0]   ONE_T    = TW'(1) << F;
    localparam logic [PW-1:0]   ONE_P    = PW'(1) << F;
    localparam logic [DW:0]     POS_MAX  = (DW + 1)'((64'd1 << (DW - 1)) - 64'd1);
    localparam logic [DW:0]     NEG_MAX  = (DW + 1)'(64'd1 << (DW - 1));

    typedef logic [TW-1:0] rom_t [TANH_TABLE_DEPTH];

    function automatic rom_t build_rom();
        rom_t        rom;
        logic [63:0] z;
        for (int i = 0; i < TANH_TABLE_DEPTH; i++)
        begin
            z      = (64'(8 * i + 4) << 23) / TANH_TABLE_DEPTH;
            rom[i] = TW'(tanh_entry(z, F));
        end
        return rom;
    endfunction

    localparam rom_t TANH_ROM = build_rom();

    logic                  accept;
    logic [NST-1:0]        vld_reg;
    logic [NST-1:0]        vld_next;
    logic [NST-1:0]        last_reg;
    logic [NST-1:0]        last_next;
    logic [NST-1:0]        neg_reg;
    logic [NST-1:0]        neg_next;
    logic [5:0]            big_reg;
    logic [5:0]            big_next;
    logic [DW-1:0]         mag_reg [7];
    logic [DW-1:0]         mag_next [7];
    logic [PW-1:0]         mp_reg [3];
    logic [PW-1:0]         mp_next [3];

    logic [F+3:0]          m2_reg;
    logic [F+3:0]          m2_next;
    logic [F+5:0]          m3_reg;
    logic [F+5:0]          m3_next;
    logic [F+2:0]          inner_reg;
    logic [F+2:0]          inner_next;
    logic [F+2:0]          u_reg;
    logic [F+2:0]          u_next;
    logic [IW-1:0]         idx_reg;
    logic [IW-1:0]         idx_next;
    logic [TW-1:0]         t_reg;
    logic [TW-1:0]         t_next;
    logic [DW:0]           y_reg;
    logic [DW:0]           y_next;

    logic                  done_reg;
    logic [DW-1:0]         sample_out_reg;
    logic [DW-1:0]         sample_out_next;
    logic                  last_out_reg;

    logic [DW-1:0]         abs_in;
    logic [2*PW-1:0]       m2_prod;
    logic [2*PW+1:0]       m3_prod;
    logic [F+COEF_W+6:0]   cubic_prod;
    logic [F+SQRT2PI_W+2:0] scale_prod;
    logic [F+IW+2:0]       idx_prod;
    logic [PW-1:0]         gain;
    logic [DW+F+1:0]       y_prod;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // stage 1: magnitude and range check
    always_comb
    begin
        abs_in      = sample_in[DW-1] ? (~sample_in + DW'(1)) : sample_in;
        vld_next    = {vld_reg[NST-2:0], accept};
        last_next   = {last_reg[NST-2:0], last_in};
        neg_next    = {neg_reg[NST-2:0], sample_in[DW-1]};
        big_next    = {big_reg[4:0], (CW'(abs_in) >= FOUR_LIM)};
        mag_next[0] = abs_in;
        for (int k = 1; k < 7; k++)
        begin
            mag_next[k] = mag_reg[k-1];
        end
        mp_next[0] = PW'(abs_in);
        mp_next[1] = mp_reg[0];
        mp_next[2] = mp_reg[1];
    end

    // stages 2 to 6: argument of tanh and table index
    always_comb
    begin
        m2_prod    = (2*PW)'(mp_reg[0]) * (2*PW)'(mp_reg[0]);
        m2_next    = m2_prod[F +: F+4];
        m3_prod    = (2*PW+2)'(m2_reg) * (2*PW+2)'(mp_reg[1]);
        m3_next    = m3_prod[F +: F+6];
        cubic_prod = (F+COEF_W+7)'(m3_reg) * (F+COEF_W+7)'(COEF_Q30);
        inner_next = (F+3)'(mp_reg[2]) + cubic_prod[Q_SHIFT +: F+3];
        scale_prod = (F+SQRT2PI_W+3)'(inner_reg) * (F+SQRT2PI_W+3)'(SQRT2PI_Q30);
        u_next     = scale_prod[Q_SHIFT +: F+3];
        idx_prod   = (F+IW+3)'(u_reg) * (F+IW+3)'(DEPTH_I);
        idx_next   = idx_prod[F+2 +: IW];
    end

    // stage 7: table read
    always_comb
    begin
        if (big_reg[5] || (idx_reg >= DEPTH_I))
        begin
            t_next = ONE_T;
        end
        else
        begin
            t_next = TANH_ROM[idx_reg[AW-1:0]];
        end
    end

    // stage 8: x * (1 +/- t) / 2
    always_comb
    begin
        gain   = neg_reg[6] ? (ONE_P - PW'(t_reg)) : (ONE_P + PW'(t_reg));
        y_prod = (DW+F+2)'(mag_reg[6]) * (DW+F+2)'(gain);
        y_next = y_prod[F+1 +: DW+1];
    end

    // output: saturate and restore sign
    always_comb
    begin
        if (!neg_reg[7])
        begin
            sample_out_next = (y_reg > POS_MAX) ? POS_MAX[DW-1:0] : y_reg[DW-1:0];
        end
        else
        begin
            sample_out_next = (y_reg > NEG_MAX) ? (DW'(0) - NEG_MAX[DW-1:0])
                                                : (DW'(0) - y_reg[DW-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= vld_next;
            done_reg <= vld_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg       <= last_next;
        neg_reg        <= neg_next;
        big_reg        <= big_next;
        mag_reg        <= mag_next;
        mp_reg         <= mp_next;
        m2_reg         <= m2_next;
        m3_reg         <= m3_next;
        inner_reg      <= inner_next;
        u_reg          <= u_next;
        idx_reg        <= idx_next;
        t_reg          <= t_next;
        y_reg          <= y_next;
        sample_out_reg <= sample_out_next;
        last_out_reg   <= last_reg[NST-1];
    end

    assign done       = done_reg;
    assign sample_out = sample_out_reg;
    assign last_out   = last_out_reg;

endmodule

// File: tb/gelu_tanh_activation_tb.sv
// ---------------------------------------------------------------------------
// gelu_tanh_activation_tb
// Self-checking bench for the streaming tanh-form GELU. Words go in through
// the start/busy handshake and every accepted word gets a predicted result
// (bit-true fixed-point GELU with its own tanh table) queued in order. Each
// done strobe is checked against the oldest prediction. Directed corner
// words come first, then random words under several sender idle patterns.
// ---------------------------------------------------------------------------
module gelu_tanh_activation_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW    = 16;
    localparam int FB    = 12;
    localparam int DEPTH = 256;

    localparam logic [63:0] C_CUBIC   = 64'd48012366;
    localparam logic [63:0] C_SQRT2PI = 64'd856722024;
    localparam logic [63:0] Q31_UNIT  = 64'd1 << 31;
    localparam logic [63:0] POS_MAX   = (64'd1 << (DW - 1)) - 1;

    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 232;

    typedef struct packed {
        logic [DW-1:0] sample;
        logic          last;
    } gelu_word_t;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          start;
    logic          busy;
    logic [DW-1:0] sample_in;
    logic          last_in;
    logic          done;
    logic [DW-1:0] sample_out;
    logic          last_out;

    logic [63:0]   tanh_rom [DEPTH];
    gelu_word_t    expected_words [$];
    int            mismatches = 0;
    int            cycles = 0;

    gelu_tanh_activation #(
        .DATA_WIDTH      (DW),
        .FRAC_BITS       (FB),
        .TANH_TABLE_DEPTH(DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .sample_in (sample_in),
        .last_in   (last_in),
        .done      (done),
        .sample_out(sample_out),
        .last_out  (last_out)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // tanh((i + 0.5) * 4 / DEPTH) in Q(.FB), via a series for exp(-2a)
    function automatic logic [63:0] tanh_sample(int unsigned i);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] z3;
        logic [63:0] z4;
        logic [63:0] e;
        logic [63:0] t;
        z  = ((64'd8 * i + 64'd4) << 23) / DEPTH;
        z2 = (z * z) >> 31;
        z3 = (z2 * z) >> 31;
        z4 = (z3 * z) >> 31;
        e  = Q31_UNIT - z + z2 / 2 - z3 / 6 + z4 / 24;
        for (int s = 0; s < 8; s++)
        begin
            e = (e * e + (Q31_UNIT >> 1)) >> 31;
        end
        t = ((Q31_UNIT - e) << 31) / (Q31_UNIT + e);
        t = (t + (64'd1 << (30 - FB))) >> (31 - FB);
        if (t > (64'd1 << FB))
        begin
            t = 64'd1 << FB;
        end
        return t;
    endfunction

    function automatic logic [DW-1:0] gelu_predict(logic [DW-1:0] x);
        logic [63:0] one;
        logic [63:0] m;
        logic [63:0] m2;
        logic [63:0] m3;
        logic [63:0] arg;
        logic [63:0] u;
        logic [63:0] idx;
        logic [63:0] t;
        logic [63:0] y;
        logic        neg;
        one = 64'd1 << FB;
        neg = x[DW-1];
        m   = neg ? ((64'd1 << DW) - {48'd0, x}) : {48'd0, x};
        if (m >= (one << 2))
        begin
            t = one;
        end
        else
        begin
            m2  = (m * m) >> FB;
            m3  = (m2 * m) >> FB;
            arg = m + ((m3 * C_CUBIC) >> 30);
            u   = (arg * C_SQRT2PI) >> 30;
            idx = (u * DEPTH) >> (FB + 2);
            t   = (idx >= DEPTH) ? one : tanh_rom[idx];
        end
        if (!neg)
        begin
            y = (m * (one + t)) >> (FB + 1);
            if (y > POS_MAX)
            begin
                y = POS_MAX;
            end
            return y[DW-1:0];
        end
        y = (m * (one - t)) >> (FB + 1);
        if (y > POS_MAX + 1)
        begin
            y = POS_MAX + 1;
        end
        y = 64'd0 - y;
        return y[DW-1:0];
    endfunction

    task automatic report_mismatch(string what, logic [DW-1:0] want, logic [DW-1:0] got);
        $display("mismatch %s: expected %h got %h at cycle %0d", what, want, got, cycles);
        mismatches++;
    endtask

    // predict on acceptance, check on done
    always @(posedge clk)
    begin
        gelu_word_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_words.size() == 0)
                begin
                    report_mismatch("unexpected word", '0, sample_out);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (sample_out !== want.sample)
                    begin
                        report_mismatch("sample_out", want.sample, sample_out);
                    end
                    if (last_out !== want.last)
                    begin
                        report_mismatch("last_out", {{(DW-1){1'b0}}, want.last},
                                        {{(DW-1){1'b0}}, last_out});
                    end
                end
            end
            if (start && !busy)
            begin
                want.sample = gelu_predict(sample_in);
                want.last   = last_in;
                expected_words.push_back(want);
            end
        end
    end

    task automatic send_word(logic [DW-1:0] x, logic l, int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        sample_in <= x;
        last_in   <= l;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
    endtask

    task automatic test_corners();
        logic [DW-1:0] words [$] = '{
            16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001,
            16'h4000, 16'h3FFF, 16'hC000, 16'hC001, 16'h1000, 16'hF000,
            16'h2000, 16'hE000, 16'h3800, 16'hC800, 16'h0800, 16'hF800,
            16'h5555, 16'hAAAA, 16'h00FF, 16'h3400
        };
        for (int i = 0; i < words.size(); i++)
        begin
            send_word(words[i], i[0], 0);
        end
    endtask

    task automatic test_random_stream(int idle_pct);
        logic [DW-1:0] x;
        logic [DW-1:0] mag;
        int            kind;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            kind = $urandom_range(3);
            if (kind == 0)
            begin
                x = DW'($urandom);
            end
            else
            begin
                mag = (kind == 3) ? DW'($urandom_range(1024)) : DW'($urandom_range(16384));
                x   = $urandom_range(1) ? -mag : mag;
            end
            send_word(x, ($urandom_range(15) == 0), idle_pct);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        sample_in = '0;
        last_in   = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tanh_rom[i] = tanh_sample(i);
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corners();
        test_random_stream(0);
        test_random_stream(61);
        // busy is never raised and no idle cycles are asked for, so this phase streams back to back
        test_random_stream(0);
        test_random_stream(10);
        start <= 1'b0;

        while (expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: gelu_tanh_activation.f
src/gelu_pkg.sv
src/gelu_tanh_activation.sv
tb/gelu_tanh_activation_tb.sv
